[rtl/core/vfal_pkg.sv]
// Package: lane count, item structs and float constants for the vector adder.
`timescale 1ns / 1ps
package vfal_pkg;
  localparam int LANES = 4;
  localparam int LANES_MAX = 4;
  localparam logic [31:0] QNAN = 32'h7FC00000;

  typedef struct packed {
    logic [31:0] a_lane0;
    logic [31:0] a_lane1;
    logic [31:0] a_lane2;
    logic [31:0] a_lane3;
    logic [31:0] b_lane0;
    logic [31:0] b_lane1;
    logic [31:0] b_lane2;
    logic [31:0] b_lane3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sum_lane0;
    logic [31:0] sum_lane1;
    logic [31:0] sum_lane2;
    logic [31:0] sum_lane3;
  } out_item_t;

  // aligned operands after stage 1
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [26:0] sb;
    logic [26:0] ss;
  } vfal_align_t;

  // raw sum after stage 2
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic [8:0]  exp;
    logic [27:0] sig;
  } vfal_sum_t;
endpackage

[rtl/core/vfal_lane.sv]
// One binary32 adder lane: align, add, normalize and round over three stages.
`timescale 1ns / 1ps
module vfal_lane
  import vfal_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] sum
);
  vfal_align_t st1_nxt, st1_r;
  vfal_sum_t   st2_nxt, st2_r;
  logic [31:0] sum_nxt, sum_r;

  // stage 1: specials, magnitude order, alignment shift with sticky
  always_comb begin
    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [26:0] sb, ss, mask;
    logic        nan_a, nan_b, inf_a, inf_b;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    sb = {(big[30:23] != '0), big[22:0], 3'b000};
    ss = {(sml[30:23] != '0), sml[22:0], 3'b000};
    d = eb - es;
    if (d >= 8'd27) begin
      mask = '0;
      ss = {26'd0, (ss != '0)};
    end else begin
      mask = (27'd1 << d[4:0]) - 27'd1;
      ss = (ss >> d[4:0]) | {26'd0, ((ss & mask) != '0)};
    end
    st1_nxt.special = nan_a || nan_b || inf_a || inf_b;
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
      st1_nxt.special_val = QNAN;
    end else if (inf_a) begin
      st1_nxt.special_val = a;
    end else begin
      st1_nxt.special_val = b;
    end
    st1_nxt.sign = big[31];
    st1_nxt.sub  = big[31] != sml[31];
    st1_nxt.exp  = eb;
    st1_nxt.sb   = sb;
    st1_nxt.ss   = ss;
  end

  // stage 2: add or subtract, carry renormalize
  always_comb begin
    logic [27:0] s;
    st2_nxt.special     = st1_r.special;
    st2_nxt.special_val = st1_r.special_val;
    st2_nxt.sign        = st1_r.sign;
    st2_nxt.exp         = {1'b0, st1_r.exp};
    if (st1_r.sub) begin
      s = {1'b0, st1_r.sb} - {1'b0, st1_r.ss};
      if (s == '0) begin
        st2_nxt.sign = 1'b0;
        st2_nxt.exp  = 9'd0;
      end
    end else begin
      s = {1'b0, st1_r.sb} + {1'b0, st1_r.ss};
      if (s[27]) begin
        s = {1'b0, s[27:2], s[1] | s[0]};
        st2_nxt.exp = {1'b0, st1_r.exp} + 9'd1;
      end
    end
    st2_nxt.sig = s;
  end

  // stage 3: leading-zero shift bounded by exponent, round to nearest even
  always_comb begin
    logic [26:0] s;
    logic [4:0]  lz;
    logic [8:0]  e, shamt;
    logic [2:0]  grs;
    logic [24:0] m;
    s  = st2_r.sig[26:0];
    e  = st2_r.exp;
    lz = 5'd27;
    for (int i = 0; i <= 26; i++) begin
      if (s[i]) lz = 5'(26 - i);
    end
    if (e == 9'd0) begin
      shamt = 9'd0;
    end else if ({4'd0, lz} < e - 9'd1) begin
      shamt = {4'd0, lz};
    end else begin
      shamt = e - 9'd1;
    end
    s = s << shamt[4:0];
    e = e - shamt;
    grs = s[2:0];
    m = {1'b0, s[26:3]};
    if (grs > 3'd4 || (grs == 3'd4 && m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      e = e + 9'd1;
    end
    if (st2_r.special) begin
      sum_nxt = st2_r.special_val;
    end else if (st2_r.exp == 9'd0) begin
      sum_nxt = 32'd0;
    end else if (e >= 9'd255) begin
      sum_nxt = {st2_r.sign, 8'hFF, 23'd0};
    end else begin
      sum_nxt = {st2_r.sign, (m[23] ? e[7:0] : 8'd0), m[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= st1_nxt;
      st2_r <= st2_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;
endmodule

[rtl/core/vfal_ctrl.sv]
// Valid tracking for the three-stage lane pipeline with stall on output.
`timescale 1ns / 1ps
module vfal_ctrl
  import vfal_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic en
);
  logic [2:0] vld_r, vld_nxt;

  // whole pipe advances unless the last stage holds an untaken item
  assign en       = !vld_r[2] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[2];
  assign vld_nxt  = en ? {vld_r[1:0], in_valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end
endmodule

[rtl/core/vector_float_add_lanes_core.sv]
// Top level: four binary32 adder lanes in parallel with a shared pipeline control.
`timescale 1ns / 1ps
// Adds two vectors of LANES binary32 values element by element, round to nearest
// even, IEEE-754 subnormals/infinities/zeros, any NaN result is 0x7FC00000.
// One item per cycle while no result waits untaken. Each item passes the align,
// add and normalize/round registers in each lane in turn; out_valid is high while
// the item sits in the last of them. Lanes at or above LANES return zero. The whole
// pipe stalls only while a result waits.
module vector_float_add_lanes_core
  import vfal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic en;
  logic [LANES_MAX-1:0][31:0] a_v, b_v, s_v;

  vfal_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .en
  );

  assign a_v = {in_data.a_lane3, in_data.a_lane2, in_data.a_lane1, in_data.a_lane0};
  assign b_v = {in_data.b_lane3, in_data.b_lane2, in_data.b_lane1, in_data.b_lane0};

  for (genvar k = 0; k < LANES_MAX; k++) begin : g_lane
    if (k < LANES) begin : g_on
      vfal_lane u_lane (.clk, .en, .a(a_v[k]), .b(b_v[k]), .sum(s_v[k]));
    end else begin : g_off
      assign s_v[k] = 32'd0;
    end
  end

  // merge lane results into the output item
  assign out_data.sum_lane0 = s_v[0];
  assign out_data.sum_lane1 = s_v[1];
  assign out_data.sum_lane2 = s_v[2];
  assign out_data.sum_lane3 = s_v[3];
endmodule
